>>> rtl/wnm_pkg.sv
// Shared types and constants for the wildcard name matcher.
package wnm_pkg;

   localparam int MAX_PATTERN = 64;
   localparam int SYMBOL_BITS = 16;

   // Port-level field widths
   localparam int SYMBOL_W    = 16;
   localparam int MODE_W      = 2;
   localparam int RSP_DATA_W  = 8;

   localparam logic [SYMBOL_W-1:0] SYM_STAR  = 16'h002A;
   localparam logic [SYMBOL_W-1:0] SYM_QUERY = 16'h003F;
   localparam logic [SYMBOL_W-1:0] SYM_LOW_A = 16'h0061;
   localparam logic [SYMBOL_W-1:0] SYM_LOW_Z = 16'h007A;
   localparam logic [SYMBOL_W-1:0] SYM_CASE  = 16'h0020;

   typedef enum logic [MODE_W-1:0] {
      MODE_CLEAR  = 2'd0,
      MODE_APPEND = 2'd1,
      MODE_NAME   = 2'd2,
      MODE_END    = 2'd3
   } wnm_mode_type;

   // Broadcast controls from the top level to every cell
   typedef struct packed {
      logic clear;
      logic rearm;
      logic step;
      logic fold_case;
   } wnm_ctrl_type;

endpackage

>>> rtl/wnm_cell.sv
// One pattern position: stored symbol, valid bit and active bit.
module wnm_cell #(
   parameter int   SymbolBits = wnm_pkg::SYMBOL_BITS,
   parameter logic IsFirst    = 1'b0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  wnm_pkg::wnm_ctrl_type ctrl,
   input  logic                  wr_en,
   input  logic [SymbolBits-1:0] sym,
   input  logic                  closed_in,
   input  logic                  adv_in,
   output logic                  act_o,
   output logic                  star_o,
   output logic                  adv_o
);

   localparam logic [SymbolBits-1:0] STAR  = SymbolBits'(wnm_pkg::SYM_STAR);
   localparam logic [SymbolBits-1:0] QUERY = SymbolBits'(wnm_pkg::SYM_QUERY);
   localparam logic [SymbolBits-1:0] LOW_A = SymbolBits'(wnm_pkg::SYM_LOW_A);
   localparam logic [SymbolBits-1:0] LOW_Z = SymbolBits'(wnm_pkg::SYM_LOW_Z);
   localparam logic [SymbolBits-1:0] CASE  = SymbolBits'(wnm_pkg::SYM_CASE);

   logic [SymbolBits-1:0] sym_ff;
   logic [SymbolBits-1:0] sym_in;
   logic                  valid_ff;
   logic                  valid_in;
   logic                  act_ff;
   logic                  act_in;
   logic                  is_star;
   logic                  is_query;
   logic                  is_equal;

   function automatic logic [SymbolBits-1:0] fold(input logic [SymbolBits-1:0] c,
                                                 input logic en);
      if (en && c >= LOW_A && c <= LOW_Z) begin
         return c - CASE;
      end
      return c;
   endfunction

   assign is_star  = (sym_ff == STAR);
   assign is_query = (sym_ff == QUERY);
   assign is_equal = (fold(sym_ff, ctrl.fold_case) == fold(sym, ctrl.fold_case));

   assign act_o  = act_ff;
   assign star_o = valid_ff & is_star;
   assign adv_o  = closed_in & valid_ff & ~is_star & (is_query | is_equal);

   always_comb begin
      sym_in = wr_en ? sym : sym_ff;

      valid_in = valid_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (wr_en) begin
         valid_in = 1'b1;
      end

      // A star holds its own position; a match hands the token to the next cell
      act_in = act_ff;
      if (ctrl.rearm) begin
         act_in = IsFirst;
      end else if (ctrl.step) begin
         act_in = (closed_in & star_o) | adv_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff <= sym_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         act_ff   <= IsFirst;
      end else begin
         valid_ff <= valid_in;
         act_ff   <= act_in;
      end
   end

endmodule

>>> rtl/wnm_closure.sv
// Star closure: each active star spreads past the run of stars after it.
module wnm_closure #(
   parameter int Width = wnm_pkg::MAX_PATTERN + 1
) (
   input  logic [Width-1:0] act,
   input  logic [Width-1:0] star,
   output logic [Width-1:0] closed
);

   logic [Width:0] gen;
   logic [Width:0] prop;
   logic [Width:0] sum;
   logic [Width:0] carry;

   // Carry into bit i+1 is star[i] & (act[i] | carry[i]): one add does the ripple
   assign prop   = {1'b0, star};
   assign gen    = {1'b0, star & act};
   assign sum    = prop + gen;
   assign carry  = sum ^ prop ^ gen;
   assign closed = act | carry[Width-1:0];

endmodule

>>> rtl/wildcard_name_matcher_core.sv
// An accepted end-of-name beat registers its result in the output register or the skid.
// Throughput: one req beat per cycle for every mode when req is not stalled; the row of
//   position cells and one star-closure adder update all positions in the same cycle.
// A two-deep result buffer (output register plus skid) stalls req only when both are full.
// Reset: empty pattern, overflow flag low, position zero active, fold_case set;
//   the pattern symbols themselves are not cleared and there is no clearing pass.
module wildcard_name_matcher_core #(
   parameter int MaxPattern = wnm_pkg::MAX_PATTERN,
   parameter int SymbolBits = wnm_pkg::SYMBOL_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [wnm_pkg::SYMBOL_W-1:0]   req_tdata,   // [15:0] symbol
   input  logic [wnm_pkg::MODE_W-1:0]     req_tuser,   // [1:0] mode
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [wnm_pkg::RSP_DATA_W-1:0] rsp_tdata,   // [0] matched, [1] pattern_overflow
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [0:0]                     csr_data     // [0] fold_case
);

   localparam int LEN_W = $clog2(MaxPattern + 1);
   localparam int POS_N = MaxPattern + 1;

   logic                  fold_case_ff;
   logic                  fold_case_in;
   logic [LEN_W-1:0]      length_ff;
   logic [LEN_W-1:0]      length_in;
   logic                  overflow_ff;
   logic                  overflow_in;
   logic                  tail_act_ff;
   logic                  tail_act_in;

   logic                  out_valid_ff;
   logic                  out_valid_in;
   logic [1:0]            out_data_ff;
   logic [1:0]            out_data_in;
   logic                  skid_valid_ff;
   logic                  skid_valid_in;
   logic [1:0]            skid_data_ff;
   logic [1:0]            skid_data_in;

   wnm_pkg::wnm_mode_type mode;
   wnm_pkg::wnm_ctrl_type ctrl;
   logic                  beat;
   logic                  is_full;
   logic                  append_ok;
   logic                  push;
   logic [1:0]            result;
   logic [SymbolBits-1:0] sym;

   logic [POS_N-1:0]      act;
   logic [POS_N-1:0]      star;
   logic [POS_N-1:0]      closed;
   logic [MaxPattern-1:0] adv;

   assign mode      = wnm_pkg::wnm_mode_type'(req_tuser);
   assign sym       = req_tdata[SymbolBits-1:0];
   assign beat      = req_tvalid & req_tready;
   assign is_full   = (length_ff == LEN_W'(MaxPattern));
   assign append_ok = beat & (mode == wnm_pkg::MODE_APPEND) & ~is_full;
   assign push      = beat & (mode == wnm_pkg::MODE_END);

   assign ctrl.clear     = beat & (mode == wnm_pkg::MODE_CLEAR);
   assign ctrl.rearm     = beat & ((mode == wnm_pkg::MODE_CLEAR) | (mode == wnm_pkg::MODE_END));
   assign ctrl.step      = beat & (mode == wnm_pkg::MODE_NAME);
   assign ctrl.fold_case = fold_case_ff;

   // Row of position cells; the last position has no symbol and is only a tail bit
   genvar gi;
   generate
      for (gi = 0; gi < MaxPattern; gi++) begin : g_cell
         wnm_cell #(
            .SymbolBits (SymbolBits),
            .IsFirst    (gi == 0)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (ctrl),
            .wr_en     (append_ok & (length_ff == LEN_W'(gi))),
            .sym       (sym),
            .closed_in (closed[gi]),
            .adv_in    ((gi == 0) ? 1'b0 : adv[(gi == 0) ? 0 : gi - 1]),
            .act_o     (act[gi]),
            .star_o    (star[gi]),
            .adv_o     (adv[gi])
         );
      end
   endgenerate

   assign act[MaxPattern]  = tail_act_ff;
   assign star[MaxPattern] = 1'b0;

   wnm_closure #(
      .Width (POS_N)
   ) u_closure (
      .act    (act),
      .star   (star),
      .closed (closed)
   );

   assign result = {overflow_ff, closed[length_ff]};

   always_comb begin
      fold_case_in = csr_valid ? csr_data[0] : fold_case_ff;

      length_in   = length_ff;
      overflow_in = overflow_ff;
      if (ctrl.clear) begin
         length_in   = '0;
         overflow_in = 1'b0;
      end else if (append_ok) begin
         length_in = length_ff + LEN_W'(1);
      end else if (beat & (mode == wnm_pkg::MODE_APPEND)) begin
         overflow_in = 1'b1;
      end

      tail_act_in = tail_act_ff;
      if (ctrl.rearm) begin
         tail_act_in = 1'b0;
      end else if (ctrl.step) begin
         tail_act_in = adv[MaxPattern-1];
      end

      // Output register with one skid entry behind it
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || rsp_tready) begin
         out_valid_in  = skid_valid_ff | push;
         out_data_in   = skid_valid_ff ? skid_data_ff : result;
         skid_valid_in = 1'b0;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_case_ff  <= 1'b1;
         length_ff     <= '0;
         overflow_ff   <= 1'b0;
         tail_act_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         fold_case_ff  <= fold_case_in;
         length_ff     <= length_in;
         overflow_ff   <= overflow_in;
         tail_act_ff   <= tail_act_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   assign req_tready = ~skid_valid_ff;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(wnm_pkg::RSP_DATA_W - 2){1'b0}}, out_data_ff};

endmodule

>>> rtl/wnm_checker.sv
// Port-level checks for the wildcard name matcher, bound to the top level.
module wnm_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [wnm_pkg::MODE_W-1:0]     req_tuser,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [wnm_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // A stalled result beat stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat dropped or changed while stalled");

   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat present after reset");

   // A fresh result only follows an accepted end-of-name beat
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready &&
                                  req_tuser == wnm_pkg::MODE_END))
      else $error("result beat without end of name");

   // Input stalls only when both result slots are held
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !$past(rsp_tready))
      else $error("input stalled with result buffer not full");

endmodule

bind wildcard_name_matcher_core wnm_checker u_wnm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> sim/wnm_checker.sv
// Scoreboard for the wildcard name matcher: tracks the pattern automaton and checks each result.
module wnm_scoreboard
   import wnm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [SYMBOL_W-1:0]   req_tdata,   // [15:0] symbol
   input  logic [MODE_W-1:0]     req_tuser,   // [1:0] mode
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,   // [0] matched, [1] pattern_overflow
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [0:0]            csr_data,    // [0] fold_case
   output int                    fail_count,
   output int                    pending,
   output int                    n_checked,
   output int                    n_matched,
   output int                    n_overflow
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [SYMBOL_W-1:0] SYM_MASK = SYMBOL_W'((1 << SYMBOL_BITS) - 1);
   localparam logic [MAX_PATTERN:0] LIVE_REARM = (MAX_PATTERN + 1)'(1);

   typedef struct packed {
      logic matched;
      logic overflow;
   } name_verdict_type;

   logic [SYMBOL_W-1:0] pat_sym [MAX_PATTERN];
   int                  pat_len;
   logic [MAX_PATTERN:0] live;
   logic                ovf;
   logic                fold_on;
   name_verdict_type    verdict_q [$];

   function automatic logic [SYMBOL_W-1:0] fold_sym(input logic [SYMBOL_W-1:0] c);
      if (fold_on && c >= SYM_LOW_A && c <= SYM_LOW_Z)
         return c - SYM_CASE;
      return c;
   endfunction

   // Let each live star also enable the position after it; cascades forward.
   task automatic spread_stars();
      for (int i = 0; i < pat_len; i++)
         if (live[i] && pat_sym[i] == SYM_STAR)
            live[i+1] = 1'b1;
   endtask

   task automatic step_name(input logic [SYMBOL_W-1:0] sym);
      logic [MAX_PATTERN:0] nxt;
      nxt = '0;
      spread_stars();
      for (int i = 0; i < pat_len; i++) begin
         if (live[i]) begin
            if (pat_sym[i] == SYM_STAR)
               nxt[i] = 1'b1;
            else if (pat_sym[i] == SYM_QUERY || fold_sym(pat_sym[i]) == fold_sym(sym))
               nxt[i+1] = 1'b1;
         end
      end
      live = nxt;
   endtask

   task automatic apply_beat(input wnm_mode_type mode, input logic [SYMBOL_W-1:0] sym);
      name_verdict_type v;
      case (mode)
         MODE_CLEAR: begin
            pat_len = 0;
            ovf     = 1'b0;
            live    = LIVE_REARM;
         end
         MODE_APPEND: begin
            if (pat_len < MAX_PATTERN) begin
               pat_sym[pat_len] = sym;
               pat_len++;
            end else begin
               ovf = 1'b1;
            end
         end
         MODE_NAME: step_name(sym);
         default: begin
            spread_stars();
            v.matched  = live[pat_len];
            v.overflow = ovf;
            verdict_q.push_back(v);
            live = LIVE_REARM;
         end
      endcase
   endtask

   always @(posedge clock) begin : track
      name_verdict_type got;
      name_verdict_type want;
      if (reset) begin
         pat_len = 0;
         ovf     = 1'b0;
         fold_on = 1'b1;
         live    = LIVE_REARM;
         verdict_q.delete();
      end else begin
         if (csr_valid && csr_ready)
            fold_on = csr_data[0];
         // Check the result beat first: it can never come from this edge's request.
         if (rsp_tvalid && rsp_tready) begin
            got.matched  = rsp_tdata[0];
            got.overflow = rsp_tdata[1];
            if (verdict_q.size() == 0) begin
               $display("%0t: result beat with no name ended: expected none, got 0x%0h",
                        $time, rsp_tdata);
               fail_count++;
            end else begin
               want = verdict_q.pop_front();
               n_checked++;
               if (want.matched)  n_matched++;
               if (want.overflow) n_overflow++;
               if (got.matched !== want.matched) begin
                  $display("%0t: matched mismatch: expected %0b, got %0b",
                           $time, want.matched, got.matched);
                  fail_count++;
               end
               if (got.overflow !== want.overflow) begin
                  $display("%0t: pattern_overflow mismatch: expected %0b, got %0b",
                           $time, want.overflow, got.overflow);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            apply_beat(wnm_mode_type'(req_tuser), req_tdata & SYM_MASK);
      end
      pending = verdict_q.size();
   end

endmodule

>>> sim/wildcard_name_matcher_core_tb.sv
// Testbench top for wildcard_name_matcher_core: drives patterns, names and fold_case writes.
module wildcard_name_matcher_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import wnm_pkg::*;

   localparam int HOLD_CYCLES = 300;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [SYMBOL_W-1:0]   req_tdata  = '0;   // [15:0] symbol
   logic [MODE_W-1:0]     req_tuser  = '0;   // [1:0] mode
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // [0] matched, [1] pattern_overflow
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [0:0]            csr_data   = '0;   // [0] fold_case

   int fail_count, pending, n_checked, n_matched, n_overflow;
   int beats_sent = 0;
   int burst_left = 0;
   bit hold_rsp   = 1'b0;
   logic [SYMBOL_W-1:0] pat_copy [$];

   wildcard_name_matcher_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   wnm_scoreboard u_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending),
      .n_checked  (n_checked),
      .n_matched  (n_matched),
      .n_overflow (n_overflow)
   );

   always #1 clock = ~clock;

   initial begin
      #1_000_000;
      $display("wildcard_name_matcher_core verification failed");
      $finish;
   end

   // Receiver: always-ready, coin-flip, mostly-ready, mostly-stalled runs; one long hold-off.
   initial begin : rsp_side
      int style;
      int span;
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end
         style = $urandom_range(0, 3);
         span  = $urandom_range(4, 30);
         repeat (span) begin
            case (style)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= 1'($urandom_range(0, 1));
               2:       rsp_tready <= ($urandom_range(0, 4) != 0);
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
            @(posedge clock);
            if (hold_rsp) break;
         end
      end
   end

   task automatic send_beat(input wnm_mode_type mode, input logic [SYMBOL_W-1:0] sym);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= sym;
      do @(posedge clock); while (!req_tready);
      beats_sent++;
      if (mode == MODE_CLEAR) pat_copy.delete();
      if (mode == MODE_APPEND) pat_copy.push_back(sym);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            req_tdata  <= SYMBOL_W'($urandom);
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Hold the input until every ended name has reported, then let the pipe settle.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_fold(input logic value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Mostly letters near the case-fold boundaries, sometimes any code unit.
   function automatic logic [SYMBOL_W-1:0] pick_letter();
      case ($urandom_range(0, 9))
         0, 1, 2: return SYMBOL_W'(16'h0061 + $urandom_range(0, 2));
         3, 4, 5: return SYMBOL_W'(16'h0041 + $urandom_range(0, 2));
         6:       return $urandom_range(0, 1) ? 16'h007A : 16'h005A;
         7:       return $urandom_range(0, 1) ? 16'h0060 : 16'h007B;
         8:       return $urandom_range(0, 1) ? 16'h0040 : 16'h005B;
         default: return SYMBOL_W'($urandom);
      endcase
   endfunction

   function automatic logic [SYMBOL_W-1:0] pick_pattern_sym();
      case ($urandom_range(0, 19))
         0, 1, 2, 3, 4: return SYM_STAR;
         5, 6, 7:       return SYM_QUERY;
         default:       return pick_letter();
      endcase
   endfunction

   function automatic bit is_letter(input logic [SYMBOL_W-1:0] s);
      return (s >= 16'h0041 && s <= 16'h005A) || (s >= SYM_LOW_A && s <= SYM_LOW_Z);
   endfunction

   // One pattern (optional) and one name, or stray beats; mostly a name built from the pattern.
   task automatic gen_record(input bit force_long);
      logic [SYMBOL_W-1:0] name_syms [$];
      logic [SYMBOL_W-1:0] s;
      int roll;
      int len;
      int k;
      roll = $urandom_range(0, 99);
      if (roll < 8 && !force_long) begin
         repeat ($urandom_range(1, 4))
            send_beat(wnm_mode_type'($urandom_range(0, 3)), SYMBOL_W'($urandom));
         return;
      end
      if (force_long || roll < 40 || pat_copy.size() > 16) begin
         send_beat(MODE_CLEAR, SYMBOL_W'($urandom));
         len = (force_long || roll == 39) ? $urandom_range(62, 70) : $urandom_range(0, 7);
         repeat (len) send_beat(MODE_APPEND, pick_pattern_sym());
      end
      if ($urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(0, 6)) name_syms.push_back(pick_letter());
      end else begin
         foreach (pat_copy[i]) begin
            s = pat_copy[i];
            if (s == SYM_STAR) begin
               repeat ($urandom_range(0, 2)) name_syms.push_back(pick_letter());
            end else if (s == SYM_QUERY) begin
               name_syms.push_back(pick_letter());
            end else begin
               if (is_letter(s) && $urandom_range(0, 1)) s = s ^ SYM_CASE;
               name_syms.push_back(s);
            end
         end
         if ($urandom_range(0, 4) == 0 && name_syms.size() > 0) begin
            k = $urandom_range(0, name_syms.size() - 1);
            case ($urandom_range(0, 2))
               0:       name_syms.delete(k);
               1:       name_syms.insert(k, pick_letter());
               default: name_syms[k] = pick_letter();
            endcase
         end
      end
      foreach (name_syms[i]) begin
         if ($urandom_range(0, 39) == 0) send_beat(MODE_APPEND, pick_pattern_sym());
         send_beat(MODE_NAME, name_syms[i]);
      end
      // Leave a few names open so they run into the next record.
      if (roll >= 97) return;
      send_beat(MODE_END, SYMBOL_W'($urandom));
   endtask

   task automatic random_phase(input int count, input bit force_long);
      int start;
      start = beats_sent;
      gen_record(force_long);
      while (beats_sent - start < count) gen_record(1'b0);
   endtask

   initial begin : stimulus
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty pattern and name, all-star pattern, folding, zero and max symbols,
      // append in the middle of a name.
      send_beat(MODE_END, 16'h0000);
      send_beat(MODE_NAME, 16'h0000);
      send_beat(MODE_END, 16'hFFFF);
      send_beat(MODE_APPEND, SYM_STAR);
      send_beat(MODE_APPEND, SYM_STAR);
      send_beat(MODE_END, 16'h0000);
      send_beat(MODE_NAME, 16'hFFFF);
      send_beat(MODE_END, 16'h0000);
      send_beat(MODE_CLEAR, 16'hFFFF);
      send_beat(MODE_APPEND, 16'h0041);
      send_beat(MODE_APPEND, SYM_QUERY);
      send_beat(MODE_APPEND, 16'h0000);
      send_beat(MODE_NAME, 16'h0061);
      send_beat(MODE_NAME, 16'hFFFF);
      send_beat(MODE_NAME, 16'h0000);
      send_beat(MODE_END, 16'h0000);
      send_beat(MODE_NAME, 16'h0061);
      send_beat(MODE_APPEND, SYM_STAR);
      send_beat(MODE_NAME, 16'h005A);
      send_beat(MODE_NAME, 16'h0000);
      send_beat(MODE_NAME, 16'h7A7A);
      send_beat(MODE_END, 16'h0000);
      send_beat(MODE_END, 16'h0000);
      send_beat(MODE_CLEAR, 16'h0000);
      send_beat(MODE_END, 16'h0000);

      drain_results();
      write_fold(1'b0);
      random_phase(170, 1'b1);

      // Stall the result side long enough to back up the input.
      hold_rsp = 1'b1;
      repeat (6) begin
         send_beat(MODE_NAME, pick_letter());
         send_beat(MODE_END, SYMBOL_W'($urandom));
      end
      drain_results();

      write_fold(1'b1);
      random_phase(170, 1'b0);
      drain_results();
      write_fold(1'b0);
      random_phase(170, 1'b1);
      drain_results();
      write_fold(1'b1);
      random_phase(170, 1'b0);

      drain_results();
      repeat (8) @(posedge clock);
      $display("Summary: %0d request beats across fold_case on/off phases and a long stall;",
               beats_sent);
      $display("  %0d results checked, %0d matches, %0d with truncated pattern",
               n_checked, n_matched, n_overflow);
      if (fail_count == 0)
         $display("wildcard_name_matcher_core verification clean");
      else
         $display("wildcard_name_matcher_core verification failed");
      $finish;
   end

endmodule
